### hw/rtl/nmt_pkg.sv
// Shared types and constants for the node measurement table.
// Holds the search token and commit beat layouts used by the cells and the top level.
// No dependencies.
package nmt_pkg;

  localparam int NMT_NODES_DEF = 16;   // default table depth
  localparam int NMT_NODES_MAX = 256;  // deepest table the index fields cover
  localparam int NMT_IDX_W     = 8;    // index width for the deepest table
  localparam int NMT_KEY_W     = 64;
  localparam int NMT_CNT_W     = 16;
  localparam int NMT_SLOT_W    = 4;
  localparam int NMT_STATUS_W  = 2;

  typedef logic [NMT_IDX_W-1:0] idx_t;
  typedef logic [NMT_KEY_W-1:0] key_t;
  typedef logic [NMT_CNT_W-1:0] cnt_t;
  typedef logic [3:0]           mtype_t;

  // Measurement type codes
  localparam mtype_t MT_CURRENT  = 4'd0;
  localparam mtype_t MT_VOLTAGE  = 4'd1;
  localparam mtype_t MT_ENERGY   = 4'd2;
  localparam mtype_t MT_ACTIVE   = 4'd3;
  localparam mtype_t MT_REACTIVE = 4'd4;
  localparam mtype_t MT_APPARENT = 4'd5;
  localparam mtype_t MT_PF       = 4'd6;
  localparam mtype_t MT_TEMP     = 4'd7;
  localparam mtype_t MT_LIGHT    = 4'd8;

  // Result status codes
  localparam logic [NMT_STATUS_W-1:0] ST_UPDATED  = 2'd0;
  localparam logic [NMT_STATUS_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [NMT_STATUS_W-1:0] ST_FULL     = 2'd2;

  // Search token walking down the cell chain
  typedef struct packed {
    logic valid;
    key_t key;
    logic hit;        // a cell with an equal key was seen
    idx_t hit_idx;
    cnt_t hit_cnt;    // packet counter of that cell
    logic empty;      // a cell with an all-zero key was seen
    idx_t empty_idx;
    cnt_t empty_cnt;
  } tok_t;

  // Write beat broadcast to every cell
  typedef struct packed {
    logic         valid;
    logic         insert;    // also write the key
    idx_t         idx;
    key_t         key;
    logic [15:0]  node_id;
    logic [7:0]   hops;
    mtype_t       meas_type;
    logic [31:0]  meas_value;
    cnt_t         count;     // counter value after the increment
  } cmt_t;

endpackage

### hw/rtl/node_measurement_table_core.sv
// Node measurement table: keyed lookup/insert over a chain of entry cells.
// The search token walks the chain one cell a cycle; the verdict is then registered and
// loaded into the output register. One report is in flight at a time: the next input beat
// is taken only in idle, but may be taken while a result still waits on the output register.
// Reset (rst_n low, synchronous): every entry is cleared to zero (empty), the channels go idle.
// Depends on nmt_pkg and nmt_cell.
module node_measurement_table_core #(
  parameter int NODES = nmt_pkg::NMT_NODES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] src_latitude, [63:32] src_longitude, [79:64] node_id, [87:80] hop_life,
  // [91:88] meas_type, [123:92] meas_value, [127:124] zero
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [5:2] slot, [21:6] packet_count, [23:22] zero
  output logic [23:0]  out_tdata
);

  // Sequencer codes
  localparam logic [1:0] S_IDLE   = 2'd0;  // wait for a report
  localparam logic [1:0] S_LAUNCH = 2'd1;  // inject the search token into cell 0
  localparam logic [1:0] S_SEARCH = 2'd2;  // token walks the chain
  localparam logic [1:0] S_DONE   = 2'd3;  // hold the verdict until the output is free

  logic [1:0]    state_r, state_nxt;

  // Captured report
  nmt_pkg::key_t   req_key_r;
  logic [15:0]     req_node_id_r;
  logic [7:0]      req_hops_r;
  nmt_pkg::mtype_t req_mtype_r;
  logic [31:0]     req_mval_r;

  // Search verdict taken off the end of the chain
  nmt_pkg::tok_t res_r;

  // Output register
  logic                               out_valid_r;
  logic [nmt_pkg::NMT_STATUS_W-1:0]   out_status_r;
  logic [nmt_pkg::NMT_SLOT_W-1:0]     out_slot_r;
  nmt_pkg::cnt_t                      out_cnt_r;

  nmt_pkg::tok_t tok_head;
  nmt_pkg::tok_t tok_chain [NODES+1];
  nmt_pkg::cmt_t cmt;

  logic                             in_fire;
  logic                             out_free;
  logic                             finish;
  logic [nmt_pkg::NMT_STATUS_W-1:0] sel_status;
  nmt_pkg::idx_t                    sel_idx;
  nmt_pkg::cnt_t                    sel_cnt;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign finish    = (state_r == S_DONE) && out_free;

  // Token head: key only, no marks yet
  always_comb begin
    tok_head       = '0;
    tok_head.valid = (state_r == S_LAUNCH);
    tok_head.key   = req_key_r;
  end

  assign tok_chain[0] = tok_head;

  for (genvar g = 0; g < NODES; g++) begin : g_cell
    nmt_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok_chain[g]),
      .tok_o (tok_chain[g+1]),
      .cmt_i (cmt)
    );
  end

  // Match beats insert; no match and no empty entry drops the report
  always_comb begin
    if (res_r.hit) begin
      sel_status = nmt_pkg::ST_UPDATED;
      sel_idx    = res_r.hit_idx;
      sel_cnt    = res_r.hit_cnt + 16'd1;
    end else if (res_r.empty) begin
      sel_status = nmt_pkg::ST_INSERTED;
      sel_idx    = res_r.empty_idx;
      sel_cnt    = res_r.empty_cnt + 16'd1;
    end else begin
      sel_status = nmt_pkg::ST_FULL;
      sel_idx    = '0;
      sel_cnt    = '0;
    end
  end

  // Broadcast the write to the chosen cell in the same cycle the result is loaded
  always_comb begin
    cmt            = '0;
    cmt.valid      = finish && (sel_status != nmt_pkg::ST_FULL);
    cmt.insert     = (sel_status == nmt_pkg::ST_INSERTED);
    cmt.idx        = sel_idx;
    cmt.key        = req_key_r;
    cmt.node_id    = req_node_id_r;
    cmt.hops       = req_hops_r;
    cmt.meas_type  = req_mtype_r;
    cmt.meas_value = req_mval_r;
    cmt.count      = sel_cnt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_SEARCH;
      S_SEARCH: if (tok_chain[NODES].valid) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_key_r     <= {in_tdata[31:0], in_tdata[63:32]};
      req_node_id_r <= in_tdata[79:64];
      req_hops_r    <= in_tdata[87:80];
      req_mtype_r   <= in_tdata[91:88];
      req_mval_r    <= in_tdata[123:92];
    end
    if ((state_r == S_SEARCH) && tok_chain[NODES].valid) begin
      res_r <= tok_chain[NODES];
    end
    if (finish) begin
      out_status_r <= sel_status;
      out_slot_r   <= sel_idx[nmt_pkg::NMT_SLOT_W-1:0];
      out_cnt_r    <= sel_cnt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_slot_r, out_status_r};

  // The token reaches the chain end only while the sequencer waits for it
  a_tok_end_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_chain[NODES].valid |-> (state_r == S_SEARCH))
    else $error("search token left the chain outside the search phase");

  // A table write happens only on the cycle the result is loaded
  a_cmt_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmt.valid |=> out_valid_r)
    else $error("table written without a result beat");

  // A dropped report carries zero slot and count
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == nmt_pkg::ST_FULL))
      |-> ((out_slot_r == '0) && (out_cnt_r == '0)))
    else $error("dropped report with nonzero slot or count");

  // An accepted report launches the token on the next cycle
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_LAUNCH))
    else $error("accepted report did not launch a search");

  // A fresh result only follows a finished search
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result beat without a finished search");

endmodule

### hw/rtl/nmt_cell.sv
// One table entry of the node measurement table, a link of the search chain.
// Compares its key against the passing token and applies commit beats for its index.
// Depends on nmt_pkg.
module nmt_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  nmt_pkg::tok_t tok_i,
  output nmt_pkg::tok_t tok_o,
  input  nmt_pkg::cmt_t cmt_i
);

  localparam nmt_pkg::idx_t MY_IDX = nmt_pkg::idx_t'(CELL_IDX);

  nmt_pkg::key_t key_r;
  logic [15:0]   node_id_r;
  logic [15:0]   current_r;
  logic [15:0]   voltage_r;
  logic [31:0]   energy_r;
  logic [31:0]   active_r;
  logic [31:0]   reactive_r;
  logic [31:0]   apparent_r;
  logic [15:0]   pf_r;
  logic [7:0]    temp_r;
  logic [15:0]   light_r;
  logic [7:0]    hops_r;
  nmt_pkg::cnt_t packets_r;

  nmt_pkg::tok_t tok_r;
  nmt_pkg::tok_t tok_nxt;
  logic          wr_en;

  // Lowest match and lowest empty win: mark only if nothing earlier did
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.valid && !tok_i.hit && (key_r == tok_i.key)) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = MY_IDX;
      tok_nxt.hit_cnt = packets_r;
    end
    if (tok_i.valid && !tok_i.empty && (key_r == '0)) begin
      tok_nxt.empty     = 1'b1;
      tok_nxt.empty_idx = MY_IDX;
      tok_nxt.empty_cnt = packets_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;
  assign wr_en = cmt_i.valid && (cmt_i.idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      node_id_r  <= '0;
      current_r  <= '0;
      voltage_r  <= '0;
      energy_r   <= '0;
      active_r   <= '0;
      reactive_r <= '0;
      apparent_r <= '0;
      pf_r       <= '0;
      temp_r     <= '0;
      light_r    <= '0;
      hops_r     <= '0;
      packets_r  <= '0;
    end else if (wr_en) begin
      if (cmt_i.insert) begin
        key_r <= cmt_i.key;
      end
      node_id_r <= cmt_i.node_id;
      hops_r    <= cmt_i.hops;
      packets_r <= cmt_i.count;
      case (cmt_i.meas_type)
        nmt_pkg::MT_CURRENT:  current_r  <= cmt_i.meas_value[15:0];
        nmt_pkg::MT_VOLTAGE:  voltage_r  <= cmt_i.meas_value[15:0];
        nmt_pkg::MT_ENERGY:   energy_r   <= cmt_i.meas_value;
        nmt_pkg::MT_ACTIVE:   active_r   <= cmt_i.meas_value;
        nmt_pkg::MT_REACTIVE: reactive_r <= cmt_i.meas_value;
        nmt_pkg::MT_APPARENT: apparent_r <= cmt_i.meas_value;
        nmt_pkg::MT_PF:       pf_r       <= cmt_i.meas_value[15:0];
        nmt_pkg::MT_TEMP:     temp_r     <= cmt_i.meas_value[7:0];
        nmt_pkg::MT_LIGHT:    light_r    <= cmt_i.meas_value[15:0];
        default: ;  // no measurement stored
      endcase
    end
  end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for node_measurement_table_core: keyed lookup/insert of position reports.
// Holds a scoreboard class that mirrors the table's keys and packet counters; depends on nmt_pkg.
// Drives directed corner reports, then random report streams under several idle/stall mixes.
module testbench;

  localparam int TABLE_DEPTH = nmt_pkg::NMT_NODES_DEF;

  // Measurement codes with no named constant in the package
  localparam nmt_pkg::mtype_t MT_NONE     = 4'd9;
  localparam nmt_pkg::mtype_t MT_LAST_RSV = 4'hF;

  localparam nmt_pkg::key_t KEY_EMPTY = '0;
  localparam nmt_pkg::key_t KEY_ONES  = '1;

  typedef struct {
    logic [nmt_pkg::NMT_STATUS_W-1:0] status;
    logic [nmt_pkg::NMT_SLOT_W-1:0]   slot;
    nmt_pkg::cnt_t                    count;
  } table_result_t;

  // Mirror of the table; only keys and counters reach the result port
  class report_scoreboard;
    nmt_pkg::key_t slot_key   [TABLE_DEPTH];
    nmt_pkg::cnt_t slot_count [TABLE_DEPTH];
    table_result_t result_q[$];
    int            mismatches;

    function new();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_key[i]   = KEY_EMPTY;
        slot_count[i] = '0;
      end
      mismatches = 0;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    // Look up the report key, claim the lowest empty slot on a miss, and queue the result
    function void note_report(logic [127:0] beat);
      nmt_pkg::key_t key;
      int            used;
      table_result_t res;
      key  = {beat[31:0], beat[63:32]};
      used = -1;
      res.status = nmt_pkg::ST_FULL;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (used < 0 && slot_key[i] == key) begin
          used = i;
          res.status = nmt_pkg::ST_UPDATED;
        end
      end
      if (used < 0) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (used < 0 && slot_key[i] == KEY_EMPTY) begin
            used = i;
            slot_key[i] = key;
            res.status = nmt_pkg::ST_INSERTED;
          end
        end
      end
      if (used < 0) begin
        res.slot  = '0;
        res.count = '0;
      end else begin
        slot_count[used] = slot_count[used] + 1'b1;
        res.slot  = used[nmt_pkg::NMT_SLOT_W-1:0];
        res.count = slot_count[used];
      end
      result_q.push_back(res);
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    // Compare a result beat against the oldest expectation
    function void check_result(logic [23:0] tdata);
      table_result_t                    want;
      logic [nmt_pkg::NMT_STATUS_W-1:0] got_status;
      logic [nmt_pkg::NMT_SLOT_W-1:0]   got_slot;
      nmt_pkg::cnt_t                    got_count;
      got_status = tdata[1:0];
      got_slot   = tdata[5:2];
      got_count  = tdata[21:6];
      if (result_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result status=%0d slot=%0d count=%0d",
                                got_status, got_slot, got_count));
        return;
      end
      want = result_q.pop_front();
      if (got_status !== want.status)
        note_mismatch($sformatf("status exp %0d got %0d", want.status, got_status));
      if (got_slot !== want.slot)
        note_mismatch($sformatf("slot exp %0d got %0d", want.slot, got_slot));
      if (got_count !== want.count)
        note_mismatch($sformatf("packet_count exp %0d got %0d", want.count, got_count));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;

  report_scoreboard sb;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  nmt_pkg::key_t seen_keys[$];

  node_measurement_table_core #(.NODES(TABLE_DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one report beat, idling first at the current rate, and hold until it is taken
  task automatic send_report(input nmt_pkg::key_t key, input logic [15:0] node,
                             input logic [7:0] hops, input nmt_pkg::mtype_t mtype,
                             input logic [31:0] value);
    logic [127:0] beat;
    beat = {4'b0, value, mtype, hops, node, key[31:0], key[63:32]};
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_report(beat);
  endtask

  // Mostly known keys, with empty keys, fresh keys and one-bit near misses mixed in
  task automatic random_report();
    nmt_pkg::key_t key;
    int            pick;
    pick = $urandom_range(99);
    if (pick < 55 && seen_keys.size() != 0) begin
      key = seen_keys[$urandom_range(seen_keys.size() - 1)];
    end else if (pick < 65) begin
      key = KEY_EMPTY;
    end else if (pick < 82 || seen_keys.size() == 0) begin
      key = {$urandom, $urandom};
      case ($urandom_range(7))
        0: key[63:32] = '0;
        1: key[31:0]  = '0;
        default: ;
      endcase
      seen_keys.push_back(key);
    end else begin
      key = seen_keys[$urandom_range(seen_keys.size() - 1)];
      key[$urandom_range(nmt_pkg::NMT_KEY_W - 1)] ^= 1'b1;
      seen_keys.push_back(key);
    end
    send_report(key, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)),
                nmt_pkg::mtype_t'($urandom_range(MT_LAST_RSV)), $urandom);
  endtask

  // Result side: check every taken beat, then pick the next ready at the current stall rate
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty key hits the lowest empty slot as an update; that slot still takes the next insert
    send_report(KEY_EMPTY, 16'h0000, 8'h00, nmt_pkg::MT_CURRENT, 32'h0000_0000);
    send_report(KEY_ONES, 16'hFFFF, 8'hFF, nmt_pkg::MT_VOLTAGE, 32'hFFFF_FFFF);
    send_report(KEY_EMPTY, 16'hFFFF, 8'hFF, MT_NONE, 32'hFFFF_FFFF);
    send_report({32'hFFFF_FFFF, 32'h0}, 16'h0000, 8'h00, nmt_pkg::MT_ENERGY, 32'h0000_0000);
    send_report({32'h0, 32'hFFFF_FFFF}, 16'hA5A5, 8'h5A, nmt_pkg::MT_LIGHT, 32'h8000_0001);
    seen_keys.push_back(KEY_ONES);
    seen_keys.push_back({32'hFFFF_FFFF, 32'h0});
    seen_keys.push_back({32'h0, 32'hFFFF_FFFF});
    // Walk every measurement code on one entry, reserved codes included
    for (int t = nmt_pkg::MT_CURRENT; t <= MT_LAST_RSV; t++) begin
      send_report(KEY_ONES, t[0] ? 16'hFFFF : 16'h0000, t[0] ? 8'h00 : 8'hFF,
                  nmt_pkg::mtype_t'(t), t[1] ? 32'hFFFF_FFFF : 32'h0000_0000);
    end

    // Random streams: no idling, sender idle, receiver stall, then both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      repeat (138) random_report();
    end
    in_tvalid <= 1'b0;

    // Drain, then give the pipeline time to show any stray beat
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * TABLE_DEPTH + 16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
